/* rtl/sba_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the slot bump allocator.
// Used by every module under rtl/ except sba_ram; depends on nothing.
package sba_pkg;

    // Default table depth
    localparam int SBA_MAX_SLOTS = 16;

    // Field widths fixed by the interface
    localparam int COUNT_W  = 16;
    localparam int FMT_W    = 8;
    localparam int SIZE_W   = 17;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 4;

    // Granularity register reset value
    localparam logic [COUNT_W-1:0] GRAN_RESET = 16'd256;

    // Register index carried in paddr[2]
    localparam logic REG_GRANULARITY = 1'b0;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_GRANTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FRAME   = 2'd3;

    // Item kind on tuser
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FRAME = 1'b1;

    // One slot table entry
    typedef struct packed {
        logic [FMT_W-1:0]  fmt;
        logic [SIZE_W-1:0] cap;
        logic [SIZE_W-1:0] rem;
    } t_slot;

    // Request to the remainder unit
    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] dividend;
        logic [COUNT_W-1:0] divisor;
    } t_rem_req;

    // Response from the remainder unit
    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] remainder;
    } t_rem_rsp;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_NEW,
        ST_FRAME,
        ST_PUSH
    } t_state;

endpackage

/* rtl/sba_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module sba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sba_rem.sv */
`timescale 1ns / 1ps
// Iterative remainder unit: count mod granularity, one quotient bit a cycle.
// Depends on sba_pkg for the request and response structs.
module sba_rem (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sba_pkg::t_rem_req     i_req,
    output sba_pkg::t_rem_rsp     o_rsp
);
    import sba_pkg::*;

    logic               r_busy;
    logic [3:0]         r_cnt;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_shift;
    logic [COUNT_W-1:0] r_div;
    logic [COUNT_W:0]   w_trial;
    logic [COUNT_W:0]   w_diff;

    // Restoring step: bring in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_shift[COUNT_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'd15;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem   <= '0;
            r_shift <= i_req.dividend;
            r_div   <= i_req.divisor;
        end else if (r_busy) begin
            r_shift <= {r_shift[COUNT_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                r_rem <= w_diff[COUNT_W-1:0];
            end else begin
                r_rem <= w_trial[COUNT_W-1:0];
            end
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.remainder = r_rem;

endmodule

/* rtl/sba_ctrl.sv */
`timescale 1ns / 1ps
// Allocator controller: slot table scan, slot opening, frame refill, result register.
// Depends on sba_pkg; drives the slot RAM and the remainder unit.
module sba_ctrl #(
    parameter int MAX_SLOTS = sba_pkg::SBA_MAX_SLOTS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [sba_pkg::COUNT_W-1:0]           i_granularity,
    // Request side
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_mode,
    input  logic [sba_pkg::COUNT_W-1:0]           i_count,
    input  logic [sba_pkg::FMT_W-1:0]             i_format_id,
    // Result side
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [sba_pkg::STATUS_W-1:0]          o_status,
    output logic [sba_pkg::IDX_W-1:0]             o_slot_index,
    output logic [sba_pkg::SIZE_W-1:0]            o_start_offset,
    output logic [sba_pkg::COUNT_W-1:0]           o_granted_count,
    // Slot RAM
    output logic                                  o_ram_we,
    output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] o_ram_waddr,
    output sba_pkg::t_slot                        o_ram_wdata,
    output logic                                  o_ram_re,
    output logic [((MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1)-1:0] o_ram_raddr,
    input  sba_pkg::t_slot                        i_ram_rdata,
    // Remainder unit
    output sba_pkg::t_rem_req                     o_rem_req,
    input  sba_pkg::t_rem_rsp                     i_rem_rsp
);
    import sba_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [CW-1:0] FULL_N = CW'(MAX_SLOTS);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_n, n_n;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_chk_vld, n_chk_vld;
    logic [AW-1:0]       r_chk_idx, n_chk_idx;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [FMT_W-1:0]    r_fmt, n_fmt;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [AW-1:0]       r_res_idx, n_res_idx;
    logic [SIZE_W-1:0]   r_res_start, n_res_start;
    logic [COUNT_W-1:0]  r_res_cnt, n_res_cnt;
    logic                r_out_vld, n_out_vld;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [IDX_W-1:0]    r_out_idx, n_out_idx;
    logic [SIZE_W-1:0]   r_out_start, n_out_start;
    logic [COUNT_W-1:0]  r_out_cnt, n_out_cnt;

    logic                w_hit;
    logic [SIZE_W-1:0]   w_count_ext;
    logic [SIZE_W-1:0]   w_new_cap;
    logic [AW+IDX_W-1:0] w_idx_ext;
    logic                w_out_free;

    assign w_count_ext = {1'b0, r_count};
    assign w_hit       = r_chk_vld && (i_ram_rdata.fmt == r_fmt)
                         && (i_ram_rdata.rem >= w_count_ext);
    // Round up: add the shortfall to the next multiple unless already aligned
    assign w_new_cap   = (i_rem_rsp.remainder == '0) ? w_count_ext
                         : w_count_ext + {1'b0, i_granularity}
                           - {1'b0, i_rem_rsp.remainder};
    assign w_idx_ext   = {{IDX_W{1'b0}}, r_res_idx};
    assign w_out_free  = !r_out_vld || i_ready;

    // State and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_n       <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_n       <= n_n;
            r_chk_vld <= n_chk_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_chk_idx    <= n_chk_idx;
        r_count      <= n_count;
        r_fmt        <= n_fmt;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_start  <= n_res_start;
        r_res_cnt    <= n_res_cnt;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_start  <= n_out_start;
        r_out_cnt    <= n_out_cnt;
    end

    // Next state and control
    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_rd_idx     = r_rd_idx;
        n_chk_vld    = r_chk_vld;
        n_chk_idx    = r_chk_idx;
        n_count      = r_count;
        n_fmt        = r_fmt;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_start  = r_res_start;
        n_res_cnt    = r_res_cnt;
        n_out_vld    = r_out_vld && !i_ready;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_start  = r_out_start;
        n_out_cnt    = r_out_cnt;

        o_ram_we     = 1'b0;
        o_ram_waddr  = r_chk_idx;
        o_ram_wdata  = i_ram_rdata;
        o_ram_re     = 1'b0;
        o_ram_raddr  = r_rd_idx[AW-1:0];

        o_rem_req.start    = 1'b0;
        o_rem_req.dividend = i_count;
        o_rem_req.divisor  = i_granularity;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_count      = i_count;
                    n_fmt        = i_format_id;
                    n_rd_idx     = '0;
                    n_chk_vld    = 1'b0;
                    n_res_idx    = '0;
                    n_res_start  = '0;
                    n_res_cnt    = '0;
                    if (i_mode == MODE_FRAME) begin
                        n_res_status = STATUS_FRAME;
                        n_state      = (r_n == '0) ? ST_PUSH : ST_FRAME;
                    end else if (i_count == '0) begin
                        n_res_status = STATUS_ZERO;
                        n_state      = ST_PUSH;
                    end else begin
                        o_rem_req.start = 1'b1;
                        n_state         = (r_n == '0) ? ST_NEW : ST_SCAN;
                    end
                end
            end

            // One read issued per cycle, checked the cycle after
            ST_SCAN: begin
                if (w_hit) begin
                    o_ram_we          = 1'b1;
                    o_ram_wdata.rem   = i_ram_rdata.rem - w_count_ext;
                    n_res_status      = STATUS_GRANTED;
                    n_res_idx         = r_chk_idx;
                    n_res_start       = i_ram_rdata.cap - i_ram_rdata.rem;
                    n_res_cnt         = r_count;
                    n_chk_vld         = 1'b0;
                    n_state           = ST_PUSH;
                end else if (r_rd_idx < r_n) begin
                    o_ram_re  = 1'b1;
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx[AW-1:0];
                end else begin
                    n_chk_vld = 1'b0;
                    if (!r_chk_vld) begin
                        if (r_n == FULL_N) begin
                            n_res_status = STATUS_FULL;
                            n_state      = ST_PUSH;
                        end else begin
                            n_state = ST_NEW;
                        end
                    end
                end
            end

            // Open a slot once the remainder is ready
            ST_NEW: begin
                if (!i_rem_rsp.busy) begin
                    o_ram_we        = 1'b1;
                    o_ram_waddr     = r_n[AW-1:0];
                    o_ram_wdata.fmt = r_fmt;
                    o_ram_wdata.cap = w_new_cap;
                    o_ram_wdata.rem = w_new_cap - w_count_ext;
                    n_n             = r_n + 1'b1;
                    n_res_status    = STATUS_GRANTED;
                    n_res_idx       = r_n[AW-1:0];
                    n_res_start     = '0;
                    n_res_cnt       = r_count;
                    n_state         = ST_PUSH;
                end
            end

            // Read entry i while writing back entry i-1 with remaining = capacity
            ST_FRAME: begin
                if (r_chk_vld) begin
                    o_ram_we        = 1'b1;
                    o_ram_wdata.rem = i_ram_rdata.cap;
                end
                if (r_rd_idx < r_n) begin
                    o_ram_re  = 1'b1;
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx[AW-1:0];
                end else begin
                    n_chk_vld = 1'b0;
                    if (!r_chk_vld) begin
                        n_state = ST_PUSH;
                    end
                end
            end

            // Hand the result to the output register once it is free
            ST_PUSH: begin
                if (w_out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_idx    = w_idx_ext[IDX_W-1:0];
                    n_out_start  = r_res_start;
                    n_out_cnt    = r_res_cnt;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready         = (r_state == ST_IDLE);
    assign o_valid         = r_out_vld;
    assign o_status        = r_out_status;
    assign o_slot_index    = r_out_idx;
    assign o_start_offset  = r_out_start;
    assign o_granted_count = r_out_cnt;

endmodule

/* rtl/slot_bump_allocator_core.sv */
`timescale 1ns / 1ps
// Slot bump allocator top level: APB register, stream ports, slot RAM and assertions.
// Depends on sba_pkg, sba_ram, sba_rem and sba_ctrl.
//
// Usage
//   Requests arrive on the s_axis group: tuser selects allocate (0) or frame
//   boundary (1), tdata carries count and format. Each request gives exactly
//   one result transaction on the m_axis group (status, slot, offset, count).
//   The granularity register (address 0, reset 256, zero acts as one) must be written
//   over APB only while the block is idle (not enforced); pready is always high.
// Flow of one request, from acceptance to the result:
//   a zero-count allocate, or a frame on an empty table, goes straight to the result;
//   an allocate scans the open slots in table order and is granted from the
//   first fit, or reports full once all MAX_SLOTS slots fail; otherwise a new slot
//   opens once the remainder unit is done; a frame refill rewrites every open slot.
//   One request is in flight at a time, set by the single slot RAM port pair (one
//   entry read per cycle, with registered read data) and the bit-serial remainder unit.
// Reset empties the table (open slot count to zero) and clears the output valid.
// A result waiting on a stalled receiver sits in the output register while
// the next request is accepted and worked on; that request only holds its
// result back until the register is free.
module slot_bump_allocator_core #(
    parameter int MAX_SLOTS = sba_pkg::SBA_MAX_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [15:0] count, [23:16] format_id
    input  logic        i_s_axis_tuser,   // [0] mode
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [1:0] status, [5:2] slot_index,
                                          // [22:6] start_offset, [38:23] granted_count,
                                          // [39] zero
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sba_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [COUNT_W-1:0]  r_granularity;
    logic [COUNT_W-1:0]  w_gran_eff;
    logic [COUNT_W-1:0]  w_count;
    logic [FMT_W-1:0]    w_fmt;
    logic [STATUS_W-1:0] w_status;
    logic [IDX_W-1:0]    w_slot_index;
    logic [SIZE_W-1:0]   w_start_offset;
    logic [COUNT_W-1:0]  w_granted_count;
    logic                w_ram_we;
    logic [AW-1:0]       w_ram_waddr;
    t_slot               w_ram_wdata;
    logic                w_ram_re;
    logic [AW-1:0]       w_ram_raddr;
    logic [$bits(t_slot)-1:0] w_ram_rdata_raw;
    t_slot               w_ram_rdata;
    t_rem_req            w_rem_req;
    t_rem_rsp            w_rem_rsp;

    // APB register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_granularity <= GRAN_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_GRANULARITY)) begin
            r_granularity <= pwdata[COUNT_W-1:0];
        end
    end

    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_GRANULARITY) ? {16'd0, r_granularity} : 32'd0;
    assign w_gran_eff = (r_granularity == '0) ? 16'd1 : r_granularity;

    // Stream field unpacking and packing
    assign w_count        = i_s_axis_tdata[15:0];
    assign w_fmt          = i_s_axis_tdata[23:16];
    assign o_m_axis_tdata = {1'b0, w_granted_count, w_start_offset, w_slot_index, w_status};

    sba_ctrl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_granularity   (w_gran_eff),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_mode          (i_s_axis_tuser),
        .i_count         (w_count),
        .i_format_id     (w_fmt),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_status        (w_status),
        .o_slot_index    (w_slot_index),
        .o_start_offset  (w_start_offset),
        .o_granted_count (w_granted_count),
        .o_ram_we        (w_ram_we),
        .o_ram_waddr     (w_ram_waddr),
        .o_ram_wdata     (w_ram_wdata),
        .o_ram_re        (w_ram_re),
        .o_ram_raddr     (w_ram_raddr),
        .i_ram_rdata     (w_ram_rdata),
        .o_rem_req       (w_rem_req),
        .i_rem_rsp       (w_rem_rsp)
    );

    // Slot table: format, capacity and remaining count per entry
    sba_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata_raw)
    );

    assign w_ram_rdata = t_slot'(w_ram_rdata_raw);

    sba_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rem_req),
        .o_rsp   (w_rem_rsp)
    );

`ifndef SYNTHESIS
    // Table writes only happen while a transaction is being worked on
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> !o_s_axis_tready)
        else $error("slot RAM written while idle");

    // An accepted non-zero allocate always starts the remainder unit
    a_rem_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == MODE_ALLOC)
         && (w_count != '0)) |=> w_rem_rsp.busy)
        else $error("remainder unit not started on allocate");

    // Writes stay inside the table
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (int'(w_ram_waddr) < MAX_SLOTS))
        else $error("slot RAM write address out of range");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for slot_bump_allocator_core: request and result streams,
// APB granularity register. Depends on sba_pkg and the RTL under rtl/.
module tb;
    import sba_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam logic [2:0] GRAN_ADDR   = {REG_GRANULARITY, 2'b00};
    localparam logic [2:0] UNUSED_ADDR = 3'd4;

    // Expected contents of one result transaction
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot;
        logic [SIZE_W-1:0]   offset;
        logic [COUNT_W-1:0]  granted;
    } t_grant;

    // Slot table shadow and queue of grants still to come
    class t_alloc_tracker;
        t_grant            pending_grants[$];
        logic [COUNT_W-1:0] granularity;
        logic [FMT_W-1:0]  fmt_tab[SBA_MAX_SLOTS];
        logic [SIZE_W-1:0] cap_tab[SBA_MAX_SLOTS];
        logic [SIZE_W-1:0] rem_tab[SBA_MAX_SLOTS];
        int unsigned       open_slots;
        int unsigned       failures;

        function new();
            granularity = GRAN_RESET;
            open_slots  = 0;
            failures    = 0;
        endfunction

        function void compare(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                if (failures < 10)
                    $display("tb: mismatch on %s: expected %0d, got %0d", what, want, got);
                failures++;
            end
        endfunction

        // Work out the grant for an accepted request and update the table
        function void note_request(logic mode, logic [COUNT_W-1:0] cnt,
                                   logic [FMT_W-1:0] fmt);
            t_grant      g;
            int          hit;
            int unsigned unit;
            g.status  = STATUS_GRANTED;
            g.slot    = '0;
            g.offset  = '0;
            g.granted = '0;
            hit       = -1;
            if (mode == MODE_FRAME) begin
                for (int k = 0; k < open_slots; k++)
                    rem_tab[k] = cap_tab[k];
                g.status = STATUS_FRAME;
            end else if (cnt == '0) begin
                g.status = STATUS_ZERO;
            end else begin
                // first fit in table order
                for (int k = 0; k < open_slots && hit < 0; k++)
                    if (fmt_tab[k] == fmt && rem_tab[k] >= cnt)
                        hit = k;
                // no fit: open a slot rounded up to the granularity
                if (hit < 0 && open_slots < SBA_MAX_SLOTS) begin
                    unit = (granularity == '0) ? 1 : 32'(granularity);
                    hit = int'(open_slots);
                    fmt_tab[hit] = fmt;
                    cap_tab[hit] = SIZE_W'(unit * ((32'(cnt) + unit - 1) / unit));
                    rem_tab[hit] = cap_tab[hit];
                    open_slots++;
                end
                if (hit < 0) begin
                    g.status = STATUS_FULL;
                end else begin
                    g.slot    = IDX_W'(hit);
                    g.offset  = cap_tab[hit] - rem_tab[hit];
                    g.granted = cnt;
                    rem_tab[hit] = rem_tab[hit] - SIZE_W'(cnt);
                end
            end
            pending_grants = {pending_grants, g};
        endfunction

        // Compare one result transaction with the oldest expected grant
        function void check_grant(logic [39:0] word);
            t_grant g;
            if (pending_grants.size() == 0) begin
                if (failures < 10)
                    $display("tb: unexpected result transaction %h", word);
                failures++;
            end else begin
                g = pending_grants.pop_front();
                compare("status", 32'(g.status), 32'(word[1:0]));
                compare("slot_index", 32'(g.slot), 32'(word[5:2]));
                compare("start_offset", 32'(g.offset), 32'(word[22:6]));
                compare("granted_count", 32'(g.granted), 32'(word[38:23]));
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;   // [15:0] count, [23:16] format_id
    logic        i_s_axis_tuser = 1'b0; // [0] mode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // [1:0] status, [5:2] slot, [22:6] offset,
                                        // [38:23] granted_count
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_alloc_tracker tracker;
    int unsigned  cycle_count = 0;
    int unsigned  rx_hold = 0;
    int unsigned  rx_span = 0;
    int unsigned  rx_style = 0;
    int unsigned  random_sent;
    int unsigned  burst_sent;
    logic [7:0]   fmt_pool [0:8] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01,
                                     8'h02, 8'h03, 8'h04, 8'h05};

    slot_bump_allocator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Result side: ready pattern is redrawn each time a random span runs out; a long hold wins
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_axis_tready = 1'b0;
        end else begin
            if (rx_span == 0) begin
                rx_style = $urandom_range(0, 3);
                rx_span  = $urandom_range(20, 300);
            end
            rx_span--;
            case (rx_style)
                0: begin
                    i_m_axis_tready = 1'b1;
                end
                1: begin
                    i_m_axis_tready = 1'($urandom_range(0, 1));
                end
                2: begin
                    i_m_axis_tready = ($urandom_range(0, 7) != 0);
                end
                default: begin
                    i_m_axis_tready = ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_grant(o_m_axis_tdata);
    end

    // One request transaction; valid stays high on return
    task send_item(input logic mode, input logic [COUNT_W-1:0] cnt,
                   input logic [FMT_W-1:0] fmt);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = mode;
        i_s_axis_tdata  = {fmt, cnt};
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.note_request(mode, cnt, fmt);
    endtask

    task pause_sender(input int unsigned cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Wait for every grant, then let the block finish any internal work
    task drain;
        pause_sender(1);
        while (tracker.pending_grants.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    // APB write followed by a read-back of the granularity register
    task write_register(input logic [2:0] addr, input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == GRAN_ADDR)
            tracker.granularity = value[COUNT_W-1:0];
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = GRAN_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.compare("granularity read-back", {16'b0, tracker.granularity}, prdata);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Mostly allocations on formats from a small pool, some frames and strays
    task send_random_item;
        logic               mode;
        logic [COUNT_W-1:0] cnt;
        logic [FMT_W-1:0]   fmt;
        int unsigned        pick;
        mode = ($urandom_range(0, 99) < 8) ? MODE_FRAME : MODE_ALLOC;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            cnt = '0;
        else if (pick < 50)
            cnt = COUNT_W'($urandom_range(1, 64));
        else if (pick < 80)
            cnt = COUNT_W'($urandom_range(1, 1024));
        else
            cnt = COUNT_W'($urandom_range(1, 65535));
        if ($urandom_range(0, 3) != 0)
            fmt = fmt_pool[$urandom_range(0, 8)];
        else
            fmt = FMT_W'($urandom_range(0, 255));
        send_item(mode, cnt, fmt);
    endtask

    // Bursts of random requests with gaps, until the count or the slot goal is reached
    task send_random(input int unsigned limit, input int unsigned slot_goal,
                     output int unsigned sent);
        int unsigned burst;
        sent = 0;
        while (sent < limit && tracker.open_slots < slot_goal) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
            while (burst > 0 && sent < limit) begin
                send_random_item();
                sent++;
                burst--;
            end
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
        end
    endtask

    initial begin
        tracker = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: default granularity
        write_register(GRAN_ADDR, 32'd256);
        send_item(MODE_ALLOC, 16'd0, 8'hFF);      // zero count
        send_item(MODE_FRAME, 16'hFFFF, 8'hFF);   // frame, fields ignored, empty table
        send_item(MODE_ALLOC, 16'd1, 8'h00);
        send_item(MODE_ALLOC, 16'd255, 8'h00);    // empties slot 0
        send_item(MODE_ALLOC, 16'd1, 8'h00);      // no room left: new slot
        send_item(MODE_ALLOC, 16'hFFFF, 8'hFF);   // capacity rounds to 2^16
        send_item(MODE_ALLOC, 16'd1, 8'hFF);
        send_item(MODE_FRAME, 16'd0, 8'h00);      // refill
        send_item(MODE_ALLOC, 16'd256, 8'h00);
        send_item(MODE_ALLOC, 16'd0, 8'h00);
        send_item(MODE_ALLOC, 16'h8000, 8'h80);
        send_item(MODE_ALLOC, 16'h7FFF, 8'h7F);
        drain();

        // Smallest granularity
        write_register(GRAN_ADDR, 32'd1);
        send_item(MODE_ALLOC, 16'd300, 8'h01);
        send_item(MODE_ALLOC, 16'd300, 8'h01);
        drain();

        // Largest granularity
        write_register(GRAN_ADDR, 32'd65535);
        send_item(MODE_ALLOC, 16'd1, 8'h02);
        send_item(MODE_ALLOC, 16'd65535, 8'h03);
        send_item(MODE_ALLOC, 16'd65534, 8'h02);
        drain();

        // Zero granularity behaves as one; a write to an unknown address changes nothing
        write_register(GRAN_ADDR, 32'd0);
        send_item(MODE_ALLOC, 16'd7, 8'h04);
        drain();
        write_register(UNUSED_ADDR, 32'd5);
        send_item(MODE_ALLOC, 16'd3, 8'h05);
        drain();

        // Random part, first setting: stop once most of the table is open
        write_register(GRAN_ADDR, ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                                              : $urandom_range(1, 65535));
        send_random(200, 13, random_sent);
        drain();

        // Second setting: table fills, then long run on a full table
        write_register(GRAN_ADDR, $urandom_range(1, 65535));
        send_random(500, SBA_MAX_SLOTS + 1, burst_sent);
        random_sent += burst_sent;
        drain();

        // Long result stall while requests keep coming
        @(posedge i_clk);
        rx_hold = 400;
        send_random(1480 - random_sent, SBA_MAX_SLOTS + 1, burst_sent);

        drain();
        repeat (40) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending_grants.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
